FILE: rtl/pipas_pkg.sv
// Shared constants, tables and types of the polygon winding-angle block.
package pipas_pkg;

  // Angle accumulator inside the arctangent unit, units of pi/2^20.
  localparam int ANG_BITS   = 23;
  // Edge angle after the four-bit rounding shift. A vector of only a few units
  // leaves the rotations short of their target, so the value can reach about
  // plus or minus 101902.
  localparam int ANGLE_BITS = 18;
  localparam int SUM_BITS   = 26;
  localparam int THR_BITS   = 16;
  localparam int TAB_LEN    = 24;
  localparam int STEP_BITS  = $clog2(TAB_LEN);

  localparam logic [THR_BITS-1:0] THR_RESET = 16'd10430;

  localparam logic signed [ANG_BITS-1:0] ANG_PI   = 23'sd1048576;
  localparam logic signed [ANG_BITS-1:0] RND_HALF = 23'sd8;
  localparam int                         RND_SHIFT = 4;

  localparam logic signed [SUM_BITS:0] SUM_HI = (SUM_BITS+1)'(2**(SUM_BITS-1) - 1);
  localparam logic signed [SUM_BITS:0] SUM_LO = -SUM_HI - (SUM_BITS+1)'(1);

  // arctan(2^-i) in units of pi/2^20.
  localparam logic [ANG_BITS-1:0] ATAN_TAB [TAB_LEN] = '{
    23'd262144, 23'd154753, 23'd81767, 23'd41506, 23'd20834, 23'd10427,
    23'd5215,   23'd2608,   23'd1304,  23'd652,   23'd326,   23'd163,
    23'd81,     23'd41,     23'd20,    23'd10,    23'd5,     23'd3,
    23'd1,      23'd1,      23'd0,     23'd0,     23'd0,     23'd0
  };

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

endpackage

FILE: rtl/pipas_ifs.sv
// Handshake channels of the polygon winding-angle block: vertex, result and configuration.
interface pipas_vtx_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
                  output ready);
endinterface

interface pipas_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  inside_res;
  logic signed [pipas_pkg::SUM_BITS-1:0] winding_sum;

  modport source (output valid, inside_res, winding_sum, input ready);
  modport sink   (input valid, inside_res, winding_sum, output ready);
endinterface

interface pipas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pipas_pkg::THR_BITS-1:0] inside_threshold;

  modport source (output valid, inside_threshold, input ready);
  modport sink   (input valid, inside_threshold, output ready);
endinterface

FILE: rtl/pipas_cordic.sv
// Iterative CORDIC atan2 unit: one rotation step per cycle, angle rounded to pi/65536.
module pipas_cordic #(
  parameter int IN_BITS = 51,
  parameter int STEPS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [IN_BITS-1:0]              x_in,
  input  logic signed [IN_BITS-1:0]              y_in,
  output logic signed [pipas_pkg::ANGLE_BITS-1:0] angle,
  output pipas_pkg::cordic_stat_t                 stat
);
  import pipas_pkg::*;

  // Two guard bits cover the CORDIC gain on a vector of length sqrt(2) times full scale.
  localparam int CW      = IN_BITS + 2;
  localparam int N_STEPS = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(N_STEPS - 1);

  typedef enum logic [1:0] {C_IDLE, C_ROT, C_RND} cstate_t;

  cstate_t                        state_r;
  logic [STEP_BITS-1:0]           step_r;
  logic signed [CW-1:0]           x_r, y_r;
  logic signed [ANG_BITS-1:0]     z_r;
  logic signed [ANGLE_BITS-1:0]   angle_r;
  logic                           done_r;

  logic signed [CW-1:0]           xe, ye, xs, ys, x_nxt, y_nxt;
  logic signed [ANG_BITS-1:0]     z_nxt, rz;
  logic                           y_pos;

  always_comb begin
    xe    = CW'(x_in);
    ye    = CW'(y_in);
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    y_pos = !y_r[CW-1] && (y_r != '0);
    if (y_pos) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + ATAN_TAB[step_r];
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - ATAN_TAB[step_r];
    end
    rz = z_r + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            step_r <= '0;
            if (x_in == '0 && y_in == '0) begin
              // A zero vector has no direction; rounding a zero angle yields zero.
              x_r     <= '0;
              y_r     <= '0;
              z_r     <= '0;
              state_r <= C_RND;
            end else if (x_in[IN_BITS-1]) begin
              // Left half plane: turn the vector by pi before rotating.
              x_r     <= -xe;
              y_r     <= -ye;
              z_r     <= y_in[IN_BITS-1] ? -ANG_PI : ANG_PI;
              state_r <= C_ROT;
            end else begin
              x_r     <= xe;
              y_r     <= ye;
              z_r     <= '0;
              state_r <= C_ROT;
            end
          end
        end
        C_ROT: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          step_r <= step_r + STEP_BITS'(1);
          if (step_r == LAST_STEP) begin
            state_r <= C_RND;
          end
        end
        C_RND: begin
          angle_r <= rz[RND_SHIFT+ANGLE_BITS-1:RND_SHIFT];
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign angle     = angle_r;
  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = done_r;

endmodule

FILE: rtl/point_in_polygon_angle_sum.sv
// Top level of the point-in-polygon test by summed winding angle.
// Vertices arrive one transfer at a time, each with the test point, and the
// last one is flagged. Each edge passes from its transfer to readiness for the
// next one through these steps: the differences, the single shared multiplier
// that forms the four products for the dot and cross products, the iterative
// arctangent unit, and the addition of the angle into the saturating sum. The
// first vertex of a polygon only opens it, unless it is also flagged last. The
// last vertex runs its own edge and then the closing edge back to the first
// vertex, and the total is then handed to the output register once it is free;
// the next polygon may begin while that result still waits.
// The threshold register resets to 10430, half a radian in units of pi/65536.
module point_in_polygon_angle_sum #(
  parameter int COORD_BITS   = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pipas_vtx_if.sink   in_vtx,
  pipas_res_if.source out_res,
  pipas_cfg_if.sink   cfg_wr
);
  import pipas_pkg::*;

  localparam int DIFF_SHIFT = (COORD_BITS > 29) ? (COORD_BITS - 29) : 0;
  localparam int DIFF_BITS  = (COORD_BITS > 29) ? 30 : (COORD_BITS + 1);
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int DOT_BITS   = PROD_BITS + 1;
  localparam logic signed [COORD_BITS:0] RND_MASK = (COORD_BITS+1)'((1 << DIFF_SHIFT) - 1);

  typedef enum logic [2:0] {S_IDLE, S_DIFF, S_MUL, S_ANG, S_ACC, S_HOLD} state_t;

  typedef enum logic [1:0] {P_US, P_VT, P_UT, P_VS} prod_sel_t;

  state_t                        state_r;
  logic signed [COORD_BITS-1:0]  cur_x_r, cur_y_r, pt_x_r, pt_y_r;
  logic signed [COORD_BITS-1:0]  first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                          last_r, closing_r, in_poly_r;
  logic signed [DIFF_BITS-1:0]   u_r, v_r, s_r, t_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [DOT_BITS-1:0]    dot_r, cross_r;
  logic [2:0]                    cnt_r;
  logic                          start_r;
  logic signed [SUM_BITS-1:0]    sum_r;
  logic [THR_BITS-1:0]           thr_r;
  logic                          out_valid_r, out_inside_r;
  logic signed [SUM_BITS-1:0]    out_total_r;

  logic signed [COORD_BITS-1:0]  ax, ay, bx, by;
  logic signed [DIFF_BITS-1:0]   mul_a, mul_b;
  logic signed [SUM_BITS:0]      sum_ext, sum_sat, mag;
  logic signed [ANGLE_BITS-1:0]  angle;
  cordic_stat_t                  cstat;
  logic                          in_fire, out_free;
  prod_sel_t                     psel, asel;

  // Truncating division by 2^DIFF_SHIFT: negative values are biased before the shift.
  function automatic logic signed [DIFF_BITS-1:0] scale_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] p
  );
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] adj;
    d          = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(p);
    adj        = d + (d[COORD_BITS] ? RND_MASK : '0);
    scale_diff = DIFF_BITS'(adj >>> DIFF_SHIFT);
  endfunction

  pipas_cordic #(
    .IN_BITS (DOT_BITS),
    .STEPS   (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .x_in  (dot_r),
    .y_in  (cross_r),
    .angle (angle),
    .stat  (cstat)
  );

  always_comb begin
    in_fire  = in_vtx.valid && in_vtx.ready;
    out_free = !out_valid_r || out_res.ready;

    // The closing edge runs from the last vertex back to the first one.
    ax = closing_r ? cur_x_r   : prev_x_r;
    ay = closing_r ? cur_y_r   : prev_y_r;
    bx = closing_r ? first_x_r : cur_x_r;
    by = closing_r ? first_y_r : cur_y_r;

    psel = prod_sel_t'(cnt_r[1:0]);
    asel = prod_sel_t'(cnt_r[1:0] - 2'd1);
    unique case (psel)
      P_US:    begin mul_a = u_r; mul_b = s_r; end
      P_VT:    begin mul_a = v_r; mul_b = t_r; end
      P_UT:    begin mul_a = u_r; mul_b = t_r; end
      P_VS:    begin mul_a = v_r; mul_b = s_r; end
      default: begin mul_a = u_r; mul_b = s_r; end
    endcase

    sum_ext = (SUM_BITS+1)'(sum_r) + (SUM_BITS+1)'(angle);
    priority if (sum_ext > SUM_HI) begin
      sum_sat = SUM_HI;
    end else if (sum_ext < SUM_LO) begin
      sum_sat = SUM_LO;
    end else begin
      sum_sat = sum_ext;
    end

    mag = sum_r[SUM_BITS-1] ? -((SUM_BITS+1)'(sum_r)) : (SUM_BITS+1)'(sum_r);
  end

  assign in_vtx.ready        = (state_r == S_IDLE);
  assign cfg_wr.ready        = 1'b1;
  assign out_res.valid       = out_valid_r;
  assign out_res.inside_res  = out_inside_r;
  assign out_res.winding_sum = out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_poly_r   <= 1'b0;
      closing_r   <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      sum_r       <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        thr_r <= cfg_wr.inside_threshold;
      end
      // In the hold state a taken result is replaced directly by the next one.
      if (out_valid_r && out_res.ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cur_x_r <= in_vtx.vertex_x;
            cur_y_r <= in_vtx.vertex_y;
            pt_x_r  <= in_vtx.point_x;
            pt_y_r  <= in_vtx.point_y;
            last_r  <= in_vtx.last_vertex;
            if (!in_poly_r) begin
              first_x_r <= in_vtx.vertex_x;
              first_y_r <= in_vtx.vertex_y;
              prev_x_r  <= in_vtx.vertex_x;
              prev_y_r  <= in_vtx.vertex_y;
              sum_r     <= '0;
              in_poly_r <= 1'b1;
              closing_r <= 1'b1;
              if (in_vtx.last_vertex) begin
                state_r <= S_DIFF;
              end
            end else begin
              closing_r <= 1'b0;
              state_r   <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          u_r   <= scale_diff(ax, pt_x_r);
          v_r   <= scale_diff(ay, pt_y_r);
          s_r   <= scale_diff(bx, pt_x_r);
          t_r   <= scale_diff(by, pt_y_r);
          cnt_r <= '0;
          if (!closing_r) begin
            prev_x_r <= cur_x_r;
            prev_y_r <= cur_y_r;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          // One product per cycle; each is folded in on the cycle after it is registered.
          prod_r <= mul_a * mul_b;
          if (cnt_r != '0) begin
            unique case (asel)
              P_US:    dot_r   <= DOT_BITS'(prod_r);
              P_VT:    dot_r   <= dot_r + DOT_BITS'(prod_r);
              P_UT:    cross_r <= DOT_BITS'(prod_r);
              P_VS:    cross_r <= cross_r - DOT_BITS'(prod_r);
              default: dot_r   <= dot_r;
            endcase
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            start_r <= 1'b1;
            state_r <= S_ANG;
          end
        end
        S_ANG: begin
          start_r <= 1'b0;
          if (cstat.done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sum_r <= SUM_BITS'(sum_sat);
          if (closing_r) begin
            state_r <= S_HOLD;
          end else if (last_r) begin
            closing_r <= 1'b1;
            state_r   <= S_DIFF;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_total_r  <= sum_r;
            out_inside_r <= (mag > (SUM_BITS+1)'(thr_r));
            sum_r        <= '0;
            in_poly_r    <= 1'b0;
            closing_r    <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_vtx.ready |-> !cstat.busy)
    else $error("vertex taken while the arctangent unit is busy");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> (state_r == S_ANG))
    else $error("arctangent result arrived outside the wait state");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> (angle <= 18'sd101902 && angle >= -(18'sd101902)))
    else $error("edge angle outside the reachable range");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(out_total_r)))
    else $error("pending total changed before its transfer");
`endif

endmodule
